/* sv/websocket_frame_deframer_assert.svh */
// Assertion macros for the WebSocket frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
`define WSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define WSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define WSD_ASSERT_IMP(lbl, ante, cons, msg)
`define WSD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/wsd_pkg.sv */
// Shared types and constants of the WebSocket frame deframer.
`default_nettype none
package wsd_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam logic [15:0] MAX_PAYLOAD_RST = 16'd15360;

  // result event codes
  localparam logic [2:0] EV_DATA       = 3'd0;
  localparam logic [2:0] EV_PING       = 3'd1;
  localparam logic [2:0] EV_PING_EMPTY = 3'd2;
  localparam logic [2:0] EV_CLOSE      = 3'd3;
  localparam logic [2:0] EV_UNKNOWN    = 3'd4;
  localparam logic [2:0] EV_TOO_BIG    = 3'd5;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;
  localparam logic [3:0] OP_PONG   = 4'd10;

  // second header byte length codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       frame_last;
  } wsd_res_t;

  typedef struct packed {
    logic halted;
    logic res_valid;
  } wsd_status_t;

endpackage
`default_nettype wire

/* sv/wsd_in_if.sv */
// Input channel: one received stream byte per transaction.
`default_nettype none
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_connection;

  modport source (output valid, output rx_byte, output new_connection, input ready);
  modport sink (input valid, input rx_byte, input new_connection, output ready);
endinterface
`default_nettype wire

/* sv/wsd_out_if.sv */
// Result channel: one deframer event per transaction.
`default_nettype none
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic       final_fragment;
  logic       frame_last;

  modport source (output valid, output event_res, output data_byte, output frame_opcode,
                  output final_fragment, output frame_last, input ready);
  modport sink (input valid, input event_res, input data_byte, input frame_opcode,
                input final_fragment, input frame_last, output ready);
endinterface
`default_nettype wire

/* sv/wsd_cfg.sv */
// APB register block holding max_payload.
`default_nettype none
module wsd_cfg
  import wsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [15:0]      max_payload
);

  logic [15:0] max_payload_r;

  // one register, so every address in range selects it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && (paddr[1:0] <= 2'd3)) begin
      max_payload_r <= pwdata[15:0];
    end
  end

  assign pready      = 1'b1;
  assign prdata      = {16'd0, max_payload_r};
  assign max_payload = max_payload_r;

endmodule
`default_nettype wire

/* sv/wsd_parser.sv */
// Frame header parser, unmasking and event decode, one byte per cycle while in_acc is set.
`default_nettype none
module wsd_parser
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_acc,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        new_connection,
  input  wire logic [15:0] max_payload,
  output wsd_status_t      status,
  output wsd_res_t         res
);

  typedef enum logic [2:0] {
    PH_B0, PH_B1, PH_EXT16, PH_EXT64, PH_MASK, PH_DATA
  } phase_t;

  phase_t                 phase_r, phase_nxt, phase_c;
  logic [2:0]             hc_r, hc_nxt, hc_c;
  logic                   fin_r, fin_nxt, fin_c;
  logic [3:0]             op_r, op_nxt, op_c;
  logic                   masked_r, masked_nxt, masked_c;
  logic [LENGTH_BITS-1:0] len_r, len_nxt, len_c;
  logic                   lhn_r, lhn_nxt, lhn_c;
  logic [31:0]            key_r, key_nxt, key_c;
  logic [15:0]            bi_r, bi_nxt, bi_c;
  logic                   halted_r, halted_nxt, halted_c;

  logic       len_done, pay_start, frm_end, last, rv;
  logic [7:0] key_byte, dat;
  wsd_res_t   r;

  // new connection wipes the parser before this byte
  always_comb begin
    if (new_connection) begin
      phase_c = PH_B0; hc_c = '0; fin_c = 1'b0; op_c = '0; masked_c = 1'b0;
      len_c = '0; lhn_c = 1'b0; key_c = '0; bi_c = '0; halted_c = 1'b0;
    end else begin
      phase_c = phase_r; hc_c = hc_r; fin_c = fin_r; op_c = op_r; masked_c = masked_r;
      len_c = len_r; lhn_c = lhn_r; key_c = key_r; bi_c = bi_r; halted_c = halted_r;
    end
  end

  always_comb begin
    case (bi_c[1:0])
      2'd0:    key_byte = key_c[31:24];
      2'd1:    key_byte = key_c[23:16];
      2'd2:    key_byte = key_c[15:8];
      default: key_byte = key_c[7:0];
    endcase
  end

  assign dat  = masked_c ? (rx_byte ^ key_byte) : rx_byte;
  assign last = (LENGTH_BITS'(17'(bi_c) + 17'd1) == len_c);

  always_comb begin
    phase_nxt = phase_c; hc_nxt = hc_c; fin_nxt = fin_c; op_nxt = op_c;
    masked_nxt = masked_c; len_nxt = len_c; lhn_nxt = lhn_c; key_nxt = key_c;
    bi_nxt = bi_c; halted_nxt = halted_c;
    len_done = 1'b0; pay_start = 1'b0; frm_end = 1'b0;
    rv = 1'b0;
    r.event_res = EV_DATA;
    r.data_byte = 8'd0;
    r.frame_last = 1'b0;

    if (!halted_c) begin
      case (phase_c)
        PH_B0: begin
          fin_nxt = rx_byte[7];
          op_nxt = rx_byte[3:0];
          masked_nxt = 1'b0; len_nxt = '0; lhn_nxt = 1'b0; key_nxt = '0; bi_nxt = '0;
          hc_nxt = '0;
          phase_nxt = PH_B1;
        end
        PH_B1: begin
          masked_nxt = rx_byte[7];
          hc_nxt = '0;
          if (rx_byte[6:0] == LEN_EXT16) begin
            phase_nxt = PH_EXT16;
          end else if (rx_byte[6:0] == LEN_EXT64) begin
            phase_nxt = PH_EXT64;
          end else begin
            len_nxt = LENGTH_BITS'(rx_byte[6:0]);
            len_done = 1'b1;
          end
        end
        PH_EXT16: begin
          lhn_nxt = lhn_c | (|len_c[LENGTH_BITS-1 -: 8]);
          len_nxt = {len_c[LENGTH_BITS-9:0], rx_byte};
          if (hc_c == 3'd1) len_done = 1'b1;
          else hc_nxt = hc_c + 3'd1;
        end
        PH_EXT64: begin
          // upper half only flags oversize
          if (hc_c < 3'd4) begin
            lhn_nxt = lhn_c | (rx_byte != 8'd0);
          end else begin
            lhn_nxt = lhn_c | (|len_c[LENGTH_BITS-1 -: 8]);
            len_nxt = {len_c[LENGTH_BITS-9:0], rx_byte};
          end
          if (hc_c == 3'd7) len_done = 1'b1;
          else hc_nxt = hc_c + 3'd1;
        end
        PH_MASK: begin
          key_nxt = {key_c[23:0], rx_byte};
          if (hc_c == 3'd3) pay_start = 1'b1;
          else hc_nxt = hc_c + 3'd1;
        end
        PH_DATA: begin
          bi_nxt = bi_c + 16'd1;
          if (last) begin
            phase_nxt = PH_B0;
            hc_nxt = '0;
          end
          if (op_c == OP_CONT || op_c == OP_TEXT || op_c == OP_BINARY) begin
            rv = 1'b1; r.event_res = EV_DATA; r.data_byte = dat; r.frame_last = last;
          end else if (op_c == OP_PING) begin
            rv = 1'b1; r.event_res = EV_PING; r.data_byte = dat; r.frame_last = last;
          end else if (op_c != OP_PONG && last) begin
            halted_nxt = 1'b1;
            rv = 1'b1;
            r.event_res = (op_c == OP_CLOSE) ? EV_CLOSE : EV_UNKNOWN;
            r.frame_last = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_B0;
          hc_nxt = '0;
        end
      endcase

      if (len_done) begin
        hc_nxt = '0;
        if (lhn_nxt || (len_nxt > LENGTH_BITS'(max_payload))) begin
          halted_nxt = 1'b1;
          phase_nxt = PH_B0;
          rv = 1'b1; r.event_res = EV_TOO_BIG; r.frame_last = 1'b1;
        end else if (masked_nxt) begin
          phase_nxt = PH_MASK;
        end else begin
          pay_start = 1'b1;
        end
      end

      if (pay_start) begin
        bi_nxt = '0;
        hc_nxt = '0;
        if (len_nxt == '0) frm_end = 1'b1;
        else phase_nxt = PH_DATA;
      end

      // empty frame closes on its last header byte
      if (frm_end) begin
        phase_nxt = PH_B0;
        hc_nxt = '0;
        if (op_c == OP_PING) begin
          rv = 1'b1; r.event_res = EV_PING_EMPTY; r.frame_last = 1'b1;
        end else if (!(op_c == OP_CONT || op_c == OP_TEXT || op_c == OP_BINARY ||
                       op_c == OP_PONG)) begin
          halted_nxt = 1'b1;
          rv = 1'b1;
          r.event_res = (op_c == OP_CLOSE) ? EV_CLOSE : EV_UNKNOWN;
          r.frame_last = 1'b1;
        end
      end
    end

    r.frame_opcode = op_c;
    r.final_fragment = fin_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_B0; hc_r <= '0; fin_r <= 1'b0; op_r <= '0; masked_r <= 1'b0;
      len_r <= '0; lhn_r <= 1'b0; key_r <= '0; bi_r <= '0; halted_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt; hc_r <= hc_nxt; fin_r <= fin_nxt; op_r <= op_nxt;
      masked_r <= masked_nxt; len_r <= len_nxt; lhn_r <= lhn_nxt; key_r <= key_nxt;
      bi_r <= bi_nxt; halted_r <= halted_nxt;
    end
  end

  assign res              = r;
  assign status.res_valid = rv;
  assign status.halted    = halted_r;

endmodule
`default_nettype wire

/* sv/wsd_out_stage.sv */
// Result register between the parser and the output channel.
`default_nettype none
module wsd_out_stage
  import wsd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire wsd_res_t res,
  output logic          free,
  wsd_out_if.source     out_ch
);

  logic     valid_r, valid_nxt;
  wsd_res_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) valid_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (free && load) res_r <= res;
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.event_res      = res_r.event_res;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.frame_opcode   = res_r.frame_opcode;
  assign out_ch.final_fragment = res_r.final_fragment;
  assign out_ch.frame_last     = res_r.frame_last;

endmodule
`default_nettype wire

/* sv/websocket_frame_deframer.sv */
// WebSocket receive deframer top level.
//
// Stream bytes of one connection enter on in_ch, one per transaction, with
// new_connection set on the first byte of a fresh connection. Each byte
// updates the header/unmask state and yields zero or one result on out_ch:
// data or ping bytes unmasked, or an event for empty ping, close, unknown
// opcode or oversize length. Close, unknown opcode and oversize halt the
// parser; bytes are then swallowed until new_connection is set.
// Throughput is one byte per cycle while in_ch.ready is high. A result
// appears on out_ch in the cycle after its byte is taken; the only storage
// between the two sides is the result register, so in_ch.ready drops only
// while that register holds a result and out_ch.ready is low. Bytes that
// yield no result still need a free result register to be taken.
// max_payload is written over APB at any address; the user must do so only
// while idle, as the block does not enforce it. Synchronous reset clears
// parser state, empties the result register and sets max_payload to 15360.
`include "websocket_frame_deframer_assert.svh"
`default_nettype none
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  wsd_in_if.sink           in_ch,
  wsd_out_if.source        out_ch
);

  logic        in_acc, free;
  logic [15:0] max_payload;
  wsd_status_t st;
  wsd_res_t    res;

  assign in_ch.ready = free;
  assign in_acc      = in_ch.valid && free;

  wsd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .max_payload (max_payload)
  );

  wsd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_acc         (in_acc),
    .rx_byte        (in_ch.rx_byte),
    .new_connection (in_ch.new_connection),
    .max_payload    (max_payload),
    .status         (st),
    .res            (res)
  );

  wsd_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (in_acc && st.res_valid),
    .res    (res),
    .free   (free),
    .out_ch (out_ch)
  );

  `WSD_ASSERT_IMP(a_no_result_halted, (st.halted && !in_ch.new_connection), (!st.res_valid), "result while halted")
  `WSD_ASSERT_NXT(a_halt_on_fatal, (in_acc && st.res_valid && (res.event_res == EV_CLOSE || res.event_res == EV_UNKNOWN || res.event_res == EV_TOO_BIG)), (st.halted), "fatal event did not halt")
  `WSD_ASSERT_IMP(a_event_ends_frame, (st.res_valid && res.event_res != EV_DATA && res.event_res != EV_PING), (res.frame_last), "event without frame end")

endmodule
`default_nettype wire

/* bench/wsd_frame_checker.sv */
// Checker for the WebSocket deframer: tracks the parser, predicts results and compares them.
module wsd_frame_checker
  import wsd_pkg::*;
#(
  parameter int         LENGTH_BITS      = LENGTH_BITS_DEF,
  parameter logic [1:0] MAX_PAYLOAD_ADDR = 2'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  wsd_in_if           in_mon,
  wsd_out_if          out_mon,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef enum logic [2:0] {
    P_HDR0, P_HDR1, P_EXT16, P_EXT64, P_KEY, P_PAYLOAD
  } parse_phase_t;

  parse_phase_t ph;
  logic [3:0]   hcnt;
  logic         fin;
  logic [3:0]   opc;
  logic         msk;
  logic [31:0]  plen;
  logic         len_big;
  logic [31:0]  key;
  logic [31:0]  idx;
  logic         halt;
  logic [15:0]  max_len;

  wsd_res_t expected_q[$];
  int       errs;
  int       n_checked;

  function automatic bit is_data_op(logic [3:0] op);
    return op == OP_CONT || op == OP_TEXT || op == OP_BINARY;
  endfunction

  function automatic wsd_res_t make_res(logic [2:0] ev, logic [7:0] d, logic is_last);
    wsd_res_t r;
    r.event_res      = ev;
    r.data_byte      = d;
    r.frame_opcode   = opc;
    r.final_fragment = fin;
    r.frame_last     = is_last;
    return r;
  endfunction

  function automatic void clear_parser();
    ph      = P_HDR0;
    hcnt    = '0;
    fin     = 1'b0;
    opc     = '0;
    msk     = 1'b0;
    plen    = '0;
    len_big = 1'b0;
    key     = '0;
    idx     = '0;
    halt    = 1'b0;
  endfunction

  function automatic void shift_length(logic [7:0] b);
    logic [39:0] t;
    t = {plen, b};
    if ((t >> LENGTH_BITS) != 0) len_big = 1'b1;
    plen = t[31:0] & 32'((64'd1 << LENGTH_BITS) - 1);
  endfunction

  // A zero-length frame ends here; ping, close and unknown opcodes report it.
  function automatic bit begin_payload(output wsd_res_t r);
    idx  = '0;
    hcnt = '0;
    r    = '0;
    if (plen != 0) begin
      ph = P_PAYLOAD;
      return 1'b0;
    end
    ph = P_HDR0;
    if (is_data_op(opc) || opc == OP_PONG) return 1'b0;
    if (opc == OP_PING) begin
      r = make_res(EV_PING_EMPTY, 8'h00, 1'b1);
      return 1'b1;
    end
    halt = 1'b1;
    r = make_res(opc == OP_CLOSE ? EV_CLOSE : EV_UNKNOWN, 8'h00, 1'b1);
    return 1'b1;
  endfunction

  function automatic bit finish_length(output wsd_res_t r);
    hcnt = '0;
    r    = '0;
    if (len_big || plen > max_len) begin
      halt = 1'b1;
      ph   = P_HDR0;
      r    = make_res(EV_TOO_BIG, 8'h00, 1'b1);
      return 1'b1;
    end
    if (msk) begin
      ph = P_KEY;
      return 1'b0;
    end
    return begin_payload(r);
  endfunction

  function automatic bit parse_byte(logic [7:0] b, logic nc, output wsd_res_t r);
    logic [1:0] k;
    logic [7:0] d;
    logic       is_last;
    r = '0;
    if (nc) clear_parser();
    if (halt) return 1'b0;
    case (ph)
      P_HDR0: begin
        fin     = b[7];
        opc     = b[3:0];
        msk     = 1'b0;
        plen    = '0;
        len_big = 1'b0;
        key     = '0;
        idx     = '0;
        hcnt    = '0;
        ph      = P_HDR1;
        return 1'b0;
      end
      P_HDR1: begin
        msk  = b[7];
        hcnt = '0;
        if (b[6:0] == LEN_EXT16) begin
          ph = P_EXT16;
          return 1'b0;
        end
        if (b[6:0] == LEN_EXT64) begin
          ph = P_EXT64;
          return 1'b0;
        end
        plen = 32'(b[6:0]);
        return finish_length(r);
      end
      P_EXT16: begin
        shift_length(b);
        hcnt = hcnt + 4'd1;
        if (hcnt >= 4'd2) return finish_length(r);
        return 1'b0;
      end
      P_EXT64: begin
        // upper half only flags an oversize length
        if (hcnt < 4'd4) begin
          if (b != 8'h00) len_big = 1'b1;
        end else begin
          shift_length(b);
        end
        hcnt = hcnt + 4'd1;
        if (hcnt >= 4'd8) return finish_length(r);
        return 1'b0;
      end
      P_KEY: begin
        key  = {key[23:0], b};
        hcnt = hcnt + 4'd1;
        if (hcnt >= 4'd4) return begin_payload(r);
        return 1'b0;
      end
      P_PAYLOAD: begin
        k       = idx[1:0];
        d       = msk ? (b ^ 8'(key >> (8 * (3 - k)))) : b;
        is_last = (idx + 32'd1 == plen);
        idx     = idx + 32'd1;
        if (is_last) begin
          ph   = P_HDR0;
          hcnt = '0;
        end
        if (is_data_op(opc)) begin
          r = make_res(EV_DATA, d, is_last);
          return 1'b1;
        end
        if (opc == OP_PING) begin
          r = make_res(EV_PING, d, is_last);
          return 1'b1;
        end
        if (opc == OP_PONG || !is_last) return 1'b0;
        halt = 1'b1;
        r = make_res(opc == OP_CLOSE ? EV_CLOSE : EV_UNKNOWN, 8'h00, 1'b1);
        return 1'b1;
      end
      default: begin
        ph   = P_HDR0;
        hcnt = '0;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic int field_bad(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch
    wsd_res_t want;
    wsd_res_t got;
    if (!rst_n) begin
      clear_parser();
      max_len = MAX_PAYLOAD_RST;
      expected_q.delete();
      errs      = 0;
      n_checked = 0;
    end else begin
      // check before predicting: a result never belongs to the byte taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.event_res, out_mon.data_byte, out_mon.frame_opcode,
                out_mon.final_fragment, out_mon.frame_last};
        if (expected_q.size() == 0) begin
          $error("unexpected result: event_res %0d data_byte %0d", got.event_res,
                 got.data_byte);
          errs++;
        end else begin
          want = expected_q.pop_front();
          errs += field_bad("event_res", want.event_res, got.event_res)
                + field_bad("data_byte", want.data_byte, got.data_byte)
                + field_bad("frame_opcode", want.frame_opcode, got.frame_opcode)
                + field_bad("final_fragment", want.final_fragment, got.final_fragment)
                + field_bad("frame_last", want.frame_last, got.frame_last);
        end
        n_checked++;
      end
      if (in_mon.valid && in_mon.ready) begin
        if (parse_byte(in_mon.rx_byte, in_mon.new_connection, want))
          expected_q.push_back(want);
      end
      if (psel && penable && pwrite && pready && paddr == MAX_PAYLOAD_ADDR)
        max_len = pwdata[15:0];
    end
    fail_count <= errs;
    checked    <= n_checked;
    pending    <= expected_q.size();
  end

endmodule

/* bench/tb_websocket_frame_deframer.sv */
// Top of the WebSocket deframer testbench: clock, reset, stream stimulus and verdict.
module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd0;
  localparam int         DRAIN_LIMIT     = 20000;

  typedef struct {
    logic [7:0] b;
    logic       nc;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  wsd_in_if  in_ch ();
  wsd_out_if out_ch ();

  int fail_count;
  int pending;
  int checked;

  stream_byte_t stream_q[$];
  int           rx_stall_pct = 0;
  logic [15:0]  gen_max;
  bit           need_reset;
  int           n_frames;
  int           n_sent;
  logic [15:0]  mid_max;

  websocket_frame_deframer u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  wsd_frame_checker #(
    .MAX_PAYLOAD_ADDR (REG_MAX_PAYLOAD)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);

  function automatic void push(logic [7:0] b, logic nc);
    stream_q.push_back('{b, nc});
  endfunction

  task automatic apb_write(logic [1:0] addr, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer queued bytes; hold a byte until it is taken.
  task automatic drive_stream(int idle_pct);
    bit live;
    live = 1'b1;
    while (live) begin
      @(posedge clk);
      if (in_ch.valid && in_ch.ready) begin
        stream_q.delete(0);
        n_sent++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (stream_q.size() == 0) begin
          in_ch.valid <= 1'b0;
          live = 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid          <= 1'b1;
          in_ch.rx_byte        <= stream_q[0].b;
          in_ch.new_connection <= stream_q[0].nc;
        end
      end
    end
  endtask

  task automatic wait_drained();
    // pending is registered, so it lags the last taken byte
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One random frame, or now and then a broken run of bytes.
  task automatic add_frame();
    logic [3:0]  op;
    logic [31:0] len;
    logic [31:0] mkey;
    logic [7:0]  hi [4];
    bit          m;
    bit          nc;
    bit          hi_over;
    int          lsel;
    int          osel;
    nc = need_reset || ($urandom_range(0, 19) == 0);
    n_frames++;
    if (need_reset && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 4)) push(8'($urandom_range(0, 255)), 1'b0);
    if ($urandom_range(0, 99) < 6) begin
      push(8'($urandom_range(0, 255)), nc);
      repeat ($urandom_range(0, 5))
        push(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      need_reset = 1'b1;
      return;
    end
    osel = $urandom_range(0, 99);
    if (osel < 60) begin
      case ($urandom_range(0, 2))
        0:       op = OP_CONT;
        1:       op = OP_TEXT;
        default: op = OP_BINARY;
      endcase
    end else if (osel < 72) begin
      op = OP_PING;
    end else if (osel < 82) begin
      op = OP_PONG;
    end else if (osel < 90) begin
      op = OP_CLOSE;
    end else begin
      do op = 4'($urandom_range(0, 15));
      while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
    end
    m       = $urandom_range(0, 1);
    mkey    = $urandom();
    hi_over = 1'b0;
    push({1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)), op}, nc);
    lsel = $urandom_range(0, 99);
    if (lsel < 70) begin
      len = (lsel < 4) ? 32'd125 : 32'($urandom_range(0, 20));
      push({m, len[6:0]}, 1'b0);
    end else if (lsel < 85) begin
      len = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 65535))
                                        : 32'($urandom_range(0, 300));
      if (len <= gen_max && len > 300) len = len % 301;
      push({m, LEN_EXT16}, 1'b0);
      push(len[15:8], 1'b0);
      push(len[7:0], 1'b0);
    end else begin
      foreach (hi[i]) hi[i] = 8'h00;
      if ($urandom_range(0, 3) == 0) begin
        foreach (hi[i]) hi[i] = 8'($urandom_range(0, 255));
        if ({hi[0], hi[1], hi[2], hi[3]} == 32'd0) hi[$urandom_range(0, 3)] = 8'h01;
        hi_over = 1'b1;
      end
      len = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 300));
      if (!hi_over && len <= gen_max && len > 300) len = len % 301;
      push({m, LEN_EXT64}, 1'b0);
      foreach (hi[i]) push(hi[i], 1'b0);
      for (int i = 3; i >= 0; i--) push(len[8*i +: 8], 1'b0);
    end
    if (hi_over || len > gen_max) begin
      need_reset = 1'b1;
      return;
    end
    if (m) for (int i = 3; i >= 0; i--) push(mkey[8*i +: 8], 1'b0);
    for (int i = 0; i < len; i++) push(8'($urandom_range(0, 255)), 1'b0);
    need_reset = !(op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_PING, OP_PONG});
  endtask

  task automatic run_phase(logic [15:0] max_len, int tx_idle, int rx_idle, int n_bytes);
    wait_drained();
    apb_write(REG_MAX_PAYLOAD, 32'(max_len));
    gen_max      = max_len;
    rx_stall_pct = rx_idle;
    while (stream_q.size() < n_bytes) add_frame();
    drive_stream(tx_idle);
  endtask

  initial begin : stimulus
    int spins;
    in_ch.valid          = 1'b0;
    in_ch.rx_byte        = '0;
    in_ch.new_connection = 1'b0;
    out_ch.ready         = 1'b0;
    need_reset           = 1'b1;
    gen_max              = MAX_PAYLOAD_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // masked text with reserved bits set, one byte
    push({1'b1, 3'b111, OP_TEXT}, 1'b1);
    push({1'b1, 7'd1}, 1'b0);
    push(8'hFF, 1'b0);
    push(8'h00, 1'b0);
    push(8'hA5, 1'b0);
    push(8'h5A, 1'b0);
    push(8'h00, 1'b0);
    // empty binary fragment, then pong payload that is dropped
    push({1'b0, 3'b000, OP_BINARY}, 1'b0);
    push(8'h00, 1'b0);
    push({1'b1, 3'b000, OP_PONG}, 1'b0);
    push(8'h01, 1'b0);
    push(8'hFF, 1'b0);
    // empty ping, then a ping byte to echo
    push({1'b1, 3'b000, OP_PING}, 1'b0);
    push(8'h00, 1'b0);
    push({1'b0, 3'b000, OP_PING}, 1'b0);
    push(8'h01, 1'b0);
    push(8'h7E, 1'b0);
    // close with payload halts; the next byte is swallowed
    push({1'b1, 3'b000, OP_CLOSE}, 1'b0);
    push(8'h01, 1'b0);
    push(8'h00, 1'b0);
    push({1'b1, 3'b000, OP_TEXT}, 1'b0);
    // unknown opcode on a fresh connection
    push({1'b1, 3'b000, 4'hF}, 1'b1);
    push(8'h00, 1'b0);
    // 16-bit length above the reset limit
    push({1'b1, 3'b000, OP_BINARY}, 1'b1);
    push({1'b0, LEN_EXT16}, 1'b0);
    push(8'hFF, 1'b0);
    push(8'hFF, 1'b0);
    rx_stall_pct = 88;
    drive_stream(32);

    mid_max = 16'($urandom_range(20, 300));
    run_phase(16'hFFFF, 32, 88, 620);
    run_phase(16'h0000, 88, 32, 150);
    run_phase(mid_max, 88, 32, 480);
    run_phase(MAX_PAYLOAD_RST, 0, 0, 600);

    spins = 0;
    while (pending != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("Sent %0d stream bytes in %0d frames and broken runs; %0d results checked.",
             n_sent, n_frames, checked);
    $display("max_payload went through 15360, 65535, 0, %0d and back to 15360.", mid_max);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
